@@ rtl/kstq_pkg.sv @@
package kstq_pkg;

   localparam int QUEUE_DEPTH_DEF = 32;
   localparam int MAX_PROCS_DEF   = 32;

   localparam int ACTION_W = 3;
   localparam int ID_W     = 5;
   localparam int KEY_W    = 16;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;
   localparam int SUM_W    = 10;

   localparam logic [ACTION_W-1:0] ACT_ENQ    = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_DEQ    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_EXISTS = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_SORT   = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_SETKEY = 3'd4;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd5;

   localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DEQ_RD,
      ST_EX_RD,
      ST_EX_CMP,
      ST_SRT_RD,
      ST_SRT_KEY,
      ST_SRT_CMP,
      ST_SRT_WB
   } state_type;

endpackage

@@ rtl/kstq_slot_mem.sv @@
module kstq_slot_mem #(
   parameter int Depth = 32
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [$clog2(Depth)-1:0]  wr_addr,
   input  logic [kstq_pkg::ID_W-1:0] wr_data,
   input  logic [$clog2(Depth)-1:0]  rd_addr,
   output logic [kstq_pkg::ID_W-1:0] rd_data
);
   import kstq_pkg::*;

   logic [ID_W-1:0] mem [Depth];
   logic [ID_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/kstq_key_mem.sv @@
module kstq_key_mem #(
   parameter int MaxProcs = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       wr_en,
   input  logic [kstq_pkg::ID_W-1:0]  wr_id,
   input  logic [kstq_pkg::KEY_W-1:0] wr_key,
   input  logic [kstq_pkg::ID_W-1:0]  rd_id,
   output logic [kstq_pkg::KEY_W-1:0] rd_key
);
   import kstq_pkg::*;

   localparam int KAW = $clog2(MaxProcs);

   logic [KEY_W-1:0] mem [MaxProcs];
   logic [MaxProcs-1:0] valid_ff;
   logic [KEY_W-1:0] key_q_ff;
   logic hit_ff;
   logic wr_ok, rd_ok;
   logic [KAW-1:0] wr_addr, rd_addr;

   // ids beyond the table never write and read as key zero
   assign wr_ok   = wr_en && (int'(wr_id) < MaxProcs);
   assign rd_ok   = int'(rd_id) < MaxProcs;
   assign wr_addr = KAW'(wr_id);
   assign rd_addr = KAW'(rd_id);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_ok) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem[wr_addr] <= wr_key;
      end
      key_q_ff <= mem[rd_addr];
      hit_ff   <= rd_ok && valid_ff[rd_addr];
   end

   assign rd_key = hit_ff ? key_q_ff : '0;

endmodule

@@ rtl/key_sorted_ready_queue.sv @@
// channel   ports                                   beat
// request   start, busy, req_action/process_id/key  start high while busy low
// response  rsp_valid, rsp_status/head_id/...       rsp_valid high for one cycle
//
// enqueue, set key, clear and unused actions respond straight from idle
// dequeue reads the head slot, then responds; exists query reads and compares each entry
// sort: bubble passes, each chaining the slot memory read and key memory read
//   per bubble step (slot read, then key read, then compare), plus a write-back
//   at the end of each pass
// reset is synchronous; the key table reads zero after reset, no clearing pass
// busy is high from an accepted multi-step beat until the response; the receiver cannot stall
module key_sorted_ready_queue #(
   parameter int QueueDepth = kstq_pkg::QUEUE_DEPTH_DEF,
   parameter int MaxProcs   = kstq_pkg::MAX_PROCS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [kstq_pkg::ACTION_W-1:0] req_action,
   input  logic [kstq_pkg::ID_W-1:0]     req_process_id,
   input  logic [kstq_pkg::KEY_W-1:0]    req_key_value,
   output logic                          rsp_valid,
   output logic [kstq_pkg::STATUS_W-1:0] rsp_status,
   output logic [kstq_pkg::ID_W-1:0]     rsp_head_id,
   output logic                          rsp_found,
   output logic [kstq_pkg::COUNT_W-1:0]  rsp_entry_count,
   output logic [kstq_pkg::SUM_W-1:0]    rsp_id_sum
);
   import kstq_pkg::*;

   localparam int AW = $clog2(QueueDepth);
   localparam int FW = $clog2(QueueDepth + 1);

   state_type state_ff, state_in;

   logic [AW-1:0]    head_ff, head_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [FW-1:0]    k_ff, k_in;
   logic [FW-1:0]    pass_ff, pass_in;
   logic [ID_W-1:0]  pid_ff, pid_in;
   logic             found_ff, found_in;
   logic [ID_W-1:0]  carry_id_ff, carry_id_in;
   logic [KEY_W-1:0] carry_key_ff, carry_key_in;
   logic [ID_W-1:0]  new_id_ff, new_id_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]     rsp_head_ff, rsp_head_in;
   logic                rsp_found_ff, rsp_found_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic [SUM_W-1:0]    rsp_sum_ff, rsp_sum_in;

   logic            slot_wr_en;
   logic [AW-1:0]   slot_wr_addr, slot_rd_addr;
   logic [ID_W-1:0] slot_wr_data, slot_rd_data;
   logic            key_wr_en;
   logic [ID_W-1:0] key_rd_id;
   logic [KEY_W-1:0] key_rd_data;

   logic accept, full, empty, goes_after, finish;

   function automatic logic [AW-1:0] phys(input logic [AW-1:0] head, input logic [FW-1:0] k);
      logic [AW:0] s;
      s = {1'b0, head} + (AW+1)'(k);
      if (s >= (AW+1)'(QueueDepth)) begin
         s = s - (AW+1)'(QueueDepth);
      end
      return s[AW-1:0];
   endfunction

   assign accept = start && (state_ff == ST_IDLE);
   assign full   = fill_ff == FW'(QueueDepth);
   assign empty  = fill_ff == '0;
   assign goes_after = (carry_key_ff > key_rd_data) ||
                       ((carry_key_ff == key_rd_data) && (carry_id_ff > new_id_ff));

   kstq_slot_mem #(.Depth(QueueDepth)) u_slot_mem (
      .clock   (clock),
      .wr_en   (slot_wr_en),
      .wr_addr (slot_wr_addr),
      .wr_data (slot_wr_data),
      .rd_addr (slot_rd_addr),
      .rd_data (slot_rd_data)
   );

   kstq_key_mem #(.MaxProcs(MaxProcs)) u_key_mem (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (key_wr_en),
      .wr_id  (req_process_id),
      .wr_key (req_key_value),
      .rd_id  (key_rd_id),
      .rd_key (key_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  ACT_DEQ:    state_in = empty ? ST_IDLE : ST_DEQ_RD;
                  ACT_EXISTS: state_in = empty ? ST_IDLE : ST_EX_RD;
                  ACT_SORT:   state_in = (fill_ff > FW'(1)) ? ST_SRT_RD : ST_IDLE;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_DEQ_RD: state_in = ST_IDLE;
         ST_EX_RD:  state_in = ST_EX_CMP;
         ST_EX_CMP: state_in = (k_ff + FW'(1) == fill_ff) ? ST_IDLE : ST_EX_RD;
         ST_SRT_RD:  state_in = ST_SRT_KEY;
         ST_SRT_KEY: state_in = ST_SRT_CMP;
         ST_SRT_CMP: state_in = (k_ff + FW'(1) == fill_ff) ? ST_SRT_WB : ST_SRT_RD;
         ST_SRT_WB:  state_in = (pass_ff + FW'(1) == fill_ff) ? ST_IDLE : ST_SRT_RD;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      head_in      = head_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      k_in         = k_ff;
      pass_in      = pass_ff;
      pid_in       = pid_ff;
      found_in     = found_ff;
      carry_id_in  = carry_id_ff;
      carry_key_in = carry_key_ff;
      new_id_in    = new_id_ff;
      slot_wr_en   = 1'b0;
      slot_wr_addr = phys(head_ff, fill_ff);
      slot_wr_data = req_process_id;
      slot_rd_addr = phys(head_ff, k_ff);
      key_wr_en    = 1'b0;
      key_rd_id    = slot_rd_data;
      finish       = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_head_in   = '0;
      rsp_found_in  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            slot_rd_addr = head_ff;
            if (accept) begin
               k_in     = '0;
               pass_in  = '0;
               pid_in   = req_process_id;
               found_in = 1'b0;
               case (req_action)
                  ACT_ENQ: begin
                     finish = 1'b1;
                     if (full) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        slot_wr_en = 1'b1;
                        fill_in    = fill_ff + FW'(1);
                        sum_in     = sum_ff + SUM_W'(req_process_id);
                     end
                  end
                  ACT_DEQ: begin
                     if (empty) begin
                        finish        = 1'b1;
                        rsp_status_in = STAT_EMPTY;
                     end
                  end
                  ACT_EXISTS: finish = empty;
                  ACT_SORT:   finish = !(fill_ff > FW'(1));
                  ACT_SETKEY: begin
                     key_wr_en = 1'b1;
                     finish    = 1'b1;
                  end
                  ACT_CLEAR: begin
                     fill_in = '0;
                     sum_in  = '0;
                     head_in = '0;
                     finish  = 1'b1;
                  end
                  default: finish = 1'b1;
               endcase
            end
         end
         ST_DEQ_RD: begin
            rsp_head_in = slot_rd_data;
            head_in     = phys(head_ff, FW'(1));
            fill_in     = fill_ff - FW'(1);
            sum_in      = sum_ff - SUM_W'(slot_rd_data);
            finish      = 1'b1;
         end
         ST_EX_CMP: begin
            found_in = found_ff || (slot_rd_data == pid_ff);
            k_in     = k_ff + FW'(1);
            if (k_ff + FW'(1) == fill_ff) begin
               finish       = 1'b1;
               rsp_found_in = found_in;
            end
         end
         ST_SRT_KEY: begin
            new_id_in = slot_rd_data;
         end
         ST_SRT_CMP: begin
            // bubble step: the larger of carry and new entry moves on
            k_in         = k_ff + FW'(1);
            slot_wr_addr = phys(head_ff, k_ff - FW'(1));
            if (k_ff == '0) begin
               carry_id_in  = new_id_ff;
               carry_key_in = key_rd_data;
            end else begin
               slot_wr_en = 1'b1;
               if (goes_after) begin
                  slot_wr_data = new_id_ff;
               end else begin
                  slot_wr_data = carry_id_ff;
                  carry_id_in  = new_id_ff;
                  carry_key_in = key_rd_data;
               end
            end
         end
         ST_SRT_WB: begin
            slot_wr_en   = 1'b1;
            slot_wr_addr = phys(head_ff, fill_ff - FW'(1));
            slot_wr_data = carry_id_ff;
            k_in         = '0;
            pass_in      = pass_ff + FW'(1);
            finish       = (pass_ff + FW'(1) == fill_ff);
         end
         default: begin
         end
      endcase
      rsp_valid_in = finish;
      rsp_count_in = COUNT_W'(fill_in);
      rsp_sum_in   = sum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff          <= k_in;
      pass_ff       <= pass_in;
      pid_ff        <= pid_in;
      found_ff      <= found_in;
      carry_id_ff   <= carry_id_in;
      carry_key_ff  <= carry_key_in;
      new_id_ff     <= new_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_sum_ff    <= rsp_sum_in;
   end

   assign busy            = state_ff != ST_IDLE;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_head_id     = rsp_head_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_id_sum      = rsp_sum_ff;

endmodule
